FILE: design/pal_pkg.sv
// Package for the positional array list: capacity, field widths, operation
// and status codes, and the control word broadcast along the chain of cells.
// No dependencies.
package pal_pkg;

    localparam int CAPACITY = 64;
    localparam int FUNC_W   = 2;
    localparam int POS_W    = 6;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_READ   = 2'd0,
        FUNC_WRITE  = 2'd1,
        FUNC_INSERT = 2'd2,
        FUNC_REMOVE = 2'd3
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK     = 2'd0,
        STATUS_FULL   = 2'd1,
        STATUS_EMPTY  = 2'd2,
        STATUS_BADPOS = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        CELL_IDLE   = 3'd0,
        CELL_WRITE  = 3'd1,
        CELL_INSERT = 3'd2,
        CELL_REMOVE = 3'd3,
        CELL_LOAD   = 3'd4,
        CELL_SHIFT  = 3'd5
    } t_cell_op;

    typedef struct packed {
        t_cell_op          op;
        logic [CMP_W-1:0]  pos;
        logic [DATA_W-1:0] value;
    } t_cell_ctrl;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_SCAN = 1'b1
    } t_state;

endpackage

FILE: design/pal_cell.sv
// One cell of the list: holds one entry and one read-scan carry register.
// Depends on pal_pkg for widths and the control word.
module pal_cell (
    input  logic                         i_clk,
    input  pal_pkg::t_cell_ctrl          i_ctrl,
    input  logic [pal_pkg::IDX_W-1:0]    i_index,
    input  logic [pal_pkg::DATA_W-1:0]   i_left,
    input  logic [pal_pkg::DATA_W-1:0]   i_right,
    input  logic [pal_pkg::DATA_W-1:0]   i_carry,
    output logic [pal_pkg::DATA_W-1:0]   o_entry,
    output logic [pal_pkg::DATA_W-1:0]   o_carry
);

    logic [pal_pkg::DATA_W-1:0] r_entry;
    logic [pal_pkg::DATA_W-1:0] n_entry;
    logic [pal_pkg::DATA_W-1:0] r_carry;
    logic [pal_pkg::DATA_W-1:0] n_carry;
    logic [pal_pkg::CMP_W-1:0]  w_index;

    assign w_index = pal_pkg::CMP_W'(i_index);

    always_comb begin
        n_entry = r_entry;
        n_carry = r_carry;
        unique case (i_ctrl.op)
            pal_pkg::CELL_WRITE: begin
                if (w_index == i_ctrl.pos) n_entry = i_ctrl.value;
            end
            pal_pkg::CELL_INSERT: begin
                // take the left neighbour above the position, the new value at it
                if (w_index > i_ctrl.pos) n_entry = i_left;
                else if (w_index == i_ctrl.pos) n_entry = i_ctrl.value;
            end
            pal_pkg::CELL_REMOVE: begin
                if (w_index >= i_ctrl.pos) n_entry = i_right;
            end
            pal_pkg::CELL_LOAD:  n_carry = r_entry;
            pal_pkg::CELL_SHIFT: n_carry = i_carry;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        r_carry <= n_carry;
    end

    assign o_entry = r_entry;
    assign o_carry = r_carry;

endmodule

FILE: design/positional_array_list.sv
// Positional array list: read, overwrite, insert or remove at a zero-based position.
// Overwrite, insert, remove and refused requests strobe a result in the cycle after
// acceptance and busy stays low, so one request per cycle. A valid read loads the
// scan chain and walks it towards cell 0, keeping busy high until the result is
// strobed. Reset (synchronous, active low) clears the count to zero; entries are
// not cleared and there is no clearing pass. The receiver cannot stall.
module positional_array_list (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic        [pal_pkg::FUNC_W-1:0]   i_func,
    input  logic        [pal_pkg::POS_W-1:0]    i_position,
    input  logic signed [pal_pkg::DATA_W-1:0]   i_value,
    output logic                                o_result_valid,
    output logic signed [pal_pkg::DATA_W-1:0]   o_read_value,
    output logic        [pal_pkg::STATUS_W-1:0] o_status,
    output logic        [pal_pkg::COUNT_W-1:0]  o_count,
    output logic                                o_is_empty,
    output logic                                o_is_full
);

    // Control state
    pal_pkg::t_state              r_state;
    pal_pkg::t_state              n_state;
    logic [pal_pkg::CNT_W-1:0]    r_count;
    logic [pal_pkg::CNT_W-1:0]    n_count;
    logic [pal_pkg::POS_W-1:0]    r_steps;
    logic [pal_pkg::POS_W-1:0]    n_steps;
    logic                         r_valid;
    logic                         n_valid;

    // Result registers (payload, no reset)
    logic [pal_pkg::DATA_W-1:0]   r_read_value;
    logic [pal_pkg::DATA_W-1:0]   n_read_value;
    pal_pkg::t_status             r_status;
    pal_pkg::t_status             n_status;
    logic [pal_pkg::CNT_W-1:0]    r_out_count;
    logic [pal_pkg::CNT_W-1:0]    n_out_count;

    pal_pkg::t_cell_ctrl          w_ctrl;
    pal_pkg::t_func               w_func;
    logic                         w_accept;
    logic [pal_pkg::CMP_W-1:0]    w_pos;
    logic [pal_pkg::CMP_W-1:0]    w_cnt;

    // Chain wiring: entries and scan carries of every cell
    logic [pal_pkg::DATA_W-1:0]   w_entry [pal_pkg::CAPACITY];
    logic [pal_pkg::DATA_W-1:0]   w_carry [pal_pkg::CAPACITY];

    assign busy     = (r_state != pal_pkg::S_IDLE);
    assign w_accept = start && !busy;
    assign w_func   = pal_pkg::t_func'(i_func);
    assign w_pos    = pal_pkg::CMP_W'(i_position);
    assign w_cnt    = pal_pkg::CMP_W'(r_count);

    // Decode the request, broadcast the cell operation and form the result
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_steps      = r_steps;
        n_valid      = 1'b0;
        n_read_value = r_read_value;
        n_status     = r_status;
        n_out_count  = r_out_count;
        w_ctrl.op    = pal_pkg::CELL_IDLE;
        w_ctrl.pos   = w_pos;
        w_ctrl.value = i_value;

        unique case (r_state)
            pal_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_valid      = 1'b1;
                    n_read_value = '0;
                    n_status     = pal_pkg::STATUS_OK;
                    unique case (w_func)
                        pal_pkg::FUNC_READ: begin
                            if (w_pos < w_cnt) begin
                                // valid read: load the scan chain, hold the strobe
                                n_valid   = 1'b0;
                                w_ctrl.op = pal_pkg::CELL_LOAD;
                                n_steps   = i_position;
                                n_state   = pal_pkg::S_SCAN;
                            end else begin
                                n_status = pal_pkg::STATUS_BADPOS;
                            end
                        end
                        pal_pkg::FUNC_WRITE: begin
                            if (w_pos < w_cnt) w_ctrl.op = pal_pkg::CELL_WRITE;
                            else n_status = pal_pkg::STATUS_BADPOS;
                        end
                        pal_pkg::FUNC_INSERT: begin
                            // full check takes priority over the position check
                            if (r_count == pal_pkg::CNT_W'(pal_pkg::CAPACITY)) begin
                                n_status = pal_pkg::STATUS_FULL;
                            end else if (w_pos > w_cnt) begin
                                n_status = pal_pkg::STATUS_BADPOS;
                            end else begin
                                w_ctrl.op = pal_pkg::CELL_INSERT;
                                n_count   = r_count + pal_pkg::CNT_W'(1);
                            end
                        end
                        default: begin
                            // remove: empty check comes first
                            if (r_count == '0) begin
                                n_status = pal_pkg::STATUS_EMPTY;
                            end else if (w_pos >= w_cnt) begin
                                n_status = pal_pkg::STATUS_BADPOS;
                            end else begin
                                w_ctrl.op = pal_pkg::CELL_REMOVE;
                                n_count   = r_count - pal_pkg::CNT_W'(1);
                            end
                        end
                    endcase
                    n_out_count = n_count;
                end
            end
            pal_pkg::S_SCAN: begin
                if (r_steps == '0) begin
                    // the addressed entry has reached cell 0: emit it
                    n_valid      = 1'b1;
                    n_read_value = w_carry[0];
                    n_status     = pal_pkg::STATUS_OK;
                    n_out_count  = r_count;
                    n_state      = pal_pkg::S_IDLE;
                end else begin
                    // advance every carry one cell towards the head
                    w_ctrl.op = pal_pkg::CELL_SHIFT;
                    n_steps   = r_steps - pal_pkg::POS_W'(1);
                end
            end
            default: n_state = pal_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pal_pkg::S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_steps      <= n_steps;
        r_read_value <= n_read_value;
        r_status     <= n_status;
        r_out_count  <= n_out_count;
    end

    // Row of cells; the ends see zero from outside the list
    for (genvar k = 0; k < pal_pkg::CAPACITY; k++) begin : g_cell
        logic [pal_pkg::DATA_W-1:0] w_left;
        logic [pal_pkg::DATA_W-1:0] w_right;
        logic [pal_pkg::DATA_W-1:0] w_carry_in;

        if (k == 0) begin : g_head
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_entry[k-1];
        end

        if (k == pal_pkg::CAPACITY - 1) begin : g_tail
            assign w_right    = '0;
            assign w_carry_in = '0;
        end else begin : g_mid_r
            assign w_right    = w_entry[k+1];
            assign w_carry_in = w_carry[k+1];
        end

        pal_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_index (pal_pkg::IDX_W'(k)),
            .i_left  (w_left),
            .i_right (w_right),
            .i_carry (w_carry_in),
            .o_entry (w_entry[k]),
            .o_carry (w_carry[k])
        );
    end

    assign o_result_valid = r_valid;
    assign o_read_value   = $signed(r_read_value);
    assign o_status       = r_status;
    assign o_count        = pal_pkg::COUNT_W'(r_out_count);
    assign o_is_empty     = (r_out_count == '0);
    assign o_is_full      = (r_out_count == pal_pkg::CNT_W'(pal_pkg::CAPACITY));

endmodule
